@@ rtl/core/constant_accel_distance_to_time_macros.svh @@
// ----------------------------------------------------------------------------
// constant_accel_distance_to_time_macros.svh
// assertion helpers shared by the square root cell and the top module
// ----------------------------------------------------------------------------
`ifndef CONSTANT_ACCEL_DISTANCE_TO_TIME_MACROS_SVH
`define CONSTANT_ACCEL_DISTANCE_TO_TIME_MACROS_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define CADT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on i_clk, off during reset
`define CADT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/cadt_pkg.sv @@
// ----------------------------------------------------------------------------
// cadt_pkg
// widths, constants and register indexes of the distance-to-time block
// ----------------------------------------------------------------------------
`default_nettype none

package cadt_pkg;

    // field widths
    localparam int LEN_W  = 23;
    localparam int SPD_W  = 20;
    localparam int FRAC_W = 17;
    localparam int TIME_W = 32;

    // radicand and root of the square root chain
    localparam int RAD_W  = 56;
    localparam int ROOT_W = RAD_W / 2;

    // one in Q1.16
    localparam logic [FRAC_W-1:0] ONE_Q16 = 17'h10000;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 23;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_TRAVEL_LENGTH = 2'd0;
    localparam t_cfg_idx CFG_START_SPEED   = 2'd1;
    localparam t_cfg_idx CFG_END_SPEED     = 2'd2;

endpackage

`default_nettype wire

@@ rtl/core/cadt_if.sv @@
// ----------------------------------------------------------------------------
// cadt_if
// valid/ready channels for query words and result words
// ----------------------------------------------------------------------------
`default_nettype none

interface cadt_in_if #(
    parameter int DIST_WIDTH = 24
);
    logic                  valid;
    logic                  ready;
    logic [DIST_WIDTH-1:0] query_distance;

    modport source (output valid, output query_distance, input ready);
    modport sink   (input valid, input query_distance, output ready);
endinterface

interface cadt_out_if import cadt_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [FRAC_W-1:0] time_fraction;
    logic [TIME_W-1:0] elapsed_time;
    logic [SPD_W-1:0]  speed_at_point;

    modport source (output valid, output time_fraction, output elapsed_time,
                    output speed_at_point, input ready);
    modport sink   (input valid, input time_fraction, input elapsed_time,
                    input speed_at_point, output ready);
endinterface

`default_nettype wire

@@ rtl/core/cadt_div_cell.sv @@
// ----------------------------------------------------------------------------
// cadt_div_cell
// one restoring division step: one quotient bit per cell
// ----------------------------------------------------------------------------
`default_nettype none

module cadt_div_cell #(
    parameter int DW = 20,
    parameter int LW = 17,
    parameter int SW = 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic          i_valid,
    input  wire logic [DW-1:0] i_div,
    input  wire logic [DW-1:0] i_rem,
    input  wire logic [LW-1:0] i_xq,
    input  wire logic [SW-1:0] i_side,
    output logic               o_valid,
    output logic      [DW-1:0] o_rem,
    output logic      [LW-1:0] o_xq,
    output logic      [SW-1:0] o_side
);

    logic          r_valid;
    logic [DW-1:0] r_rem;
    logic [LW-1:0] r_xq;
    logic [SW-1:0] r_side;
    logic [DW:0]   w_trial;
    logic [DW:0]   w_diff;
    logic          w_bit;
    logic [DW-1:0] n_rem;
    logic [LW-1:0] n_xq;

    // shift in next dividend bit, subtract if it fits
    assign w_trial = {i_rem, i_xq[LW-1]};
    assign w_diff  = w_trial - {1'b0, i_div};
    assign w_bit   = (w_trial >= {1'b0, i_div});
    assign n_rem   = w_bit ? w_diff[DW-1:0] : w_trial[DW-1:0];
    assign n_xq    = {i_xq[LW-2:0], w_bit};

    // valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_rem;
            r_xq   <= n_xq;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_xq    = r_xq;
    assign o_side  = r_side;

endmodule

`default_nettype wire

@@ rtl/core/cadt_sqrt_cell.sv @@
// ----------------------------------------------------------------------------
// cadt_sqrt_cell
// one digit-by-digit square root step: one root bit per cell
// ----------------------------------------------------------------------------
`default_nettype none

`include "constant_accel_distance_to_time_macros.svh"

module cadt_sqrt_cell #(
    parameter int QW = 56,
    parameter int SW = 17
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_en,
    input  wire logic            i_valid,
    input  wire logic [QW/2+1:0] i_rem,
    input  wire logic [QW/2-1:0] i_root,
    input  wire logic [QW-1:0]   i_qx,
    input  wire logic [SW-1:0]   i_side,
    output logic                 o_valid,
    output logic      [QW/2+1:0] o_rem,
    output logic      [QW/2-1:0] o_root,
    output logic      [QW-1:0]   o_qx,
    output logic      [SW-1:0]   o_side
);

    localparam int RW = QW / 2 + 2;
    localparam int TW = QW / 2;

    logic          r_valid;
    logic [RW-1:0] r_rem;
    logic [TW-1:0] r_root;
    logic [QW-1:0] r_qx;
    logic [SW-1:0] r_side;
    logic [RW+1:0] w_t;
    logic [RW+1:0] w_trial;
    logic [RW+1:0] w_diff;
    logic          w_ge;

    // bring in two radicand bits, try root*4+1
    assign w_t     = {i_rem, i_qx[QW-1:QW-2]};
    assign w_trial = {2'b00, i_root, 2'b01};
    assign w_diff  = w_t - w_trial;
    assign w_ge    = (w_t >= w_trial);

    // valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= w_ge ? w_diff[RW-1:0] : w_t[RW-1:0];
            r_root <= {i_root[TW-2:0], w_ge};
            r_qx   <= {i_qx[QW-3:0], 2'b00};
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_root  = r_root;
    assign o_qx    = r_qx;
    assign o_side  = r_side;

    // remainder never exceeds twice the partial root
    `CADT_ASSERT_NOW(a_rem_bound, r_valid, ({1'b0, r_rem} <= {2'b00, r_root, 1'b0}), "sqrt remainder out of range")

endmodule

`default_nettype wire

@@ rtl/core/constant_accel_distance_to_time.sv @@
// ----------------------------------------------------------------------------
// constant_accel_distance_to_time
// distance to time fraction, elapsed time and speed for a linear speed ramp
// ----------------------------------------------------------------------------
//  channel   dir   handshake      payload
//  i_in      in    valid/ready    query_distance
//  o_out     out   valid/ready    time_fraction, elapsed_time, speed_at_point
//  i_cfg_*   in    write enable   travel_length, start_speed, end_speed
//
//  one word per cycle unless stalled at the output; pipeline mainly of three
//  long division chains (16, 17 and 32 cells) and the 28-cell square root chain
//  synchronous active-low reset clears all valid bits and the configuration registers
//  a word waiting at the output stalls the whole chain for that cycle
// ----------------------------------------------------------------------------
`default_nettype none

`include "constant_accel_distance_to_time_macros.svh"

module constant_accel_distance_to_time import cadt_pkg::*; #(
    parameter int DIST_WIDTH      = 24,
    parameter int SPEED_FRAC_BITS = 8
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    cadt_in_if.sink                    i_in,
    cadt_out_if.source                 o_out
);

    localparam int CW   = (DIST_WIDTH > LEN_W) ? DIST_WIDTH : LEN_W;
    localparam int S1N  = 16;
    localparam int S2N  = FRAC_W;
    localparam int S3N  = TIME_W;
    localparam int DEN_W = SPD_W;
    localparam int VS_W = SPD_W + 1 + 8;
    localparam int NW   = LEN_W + FRAC_W + SPEED_FRAC_BITS + 1;
    localparam int HW   = NW - TIME_W;
    localparam int SQ_W = 2 * SPD_W;
    localparam int PP_W = SPD_W + FRAC_W;
    localparam int SD3_W = 2 + FRAC_W + SPD_W;

    // configuration registers
    logic [LEN_W-1:0] r_len;
    logic [SPD_W-1:0] r_v0;
    logic [SPD_W-1:0] r_v1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
            r_v0  <= '0;
            r_v1  <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_TRAVEL_LENGTH: r_len <= i_cfg_data[LEN_W-1:0];
                CFG_START_SPEED:   r_v0  <= i_cfg_data[SPD_W-1:0];
                CFG_END_SPEED:     r_v1  <= i_cfg_data[SPD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // values derived from the configuration
    logic [SQ_W-1:0]  r_v0sq;
    logic [SQ_W-1:0]  r_v1sq;
    logic [DEN_W-1:0] r_den;
    logic             r_inc;
    logic             r_eq;
    logic [VS_W-1:0]  r_vs8;

    always_ff @(posedge i_clk) begin
        r_v0sq <= SQ_W'(r_v0) * SQ_W'(r_v0);
        r_v1sq <= SQ_W'(r_v1) * SQ_W'(r_v1);
        r_den  <= (r_v1 > r_v0) ? (r_v1 - r_v0) : (r_v0 - r_v1);
        r_inc  <= (r_v1 > r_v0);
        r_eq   <= (r_v1 == r_v0);
        r_vs8  <= {(SPD_W + 1)'(r_v0) + (SPD_W + 1)'(r_v1), 8'h00};
    end

    // global advance: move unless a word waits at the output
    logic r_out_valid;
    logic w_en;

    assign w_en       = !r_out_valid || o_out.ready;
    assign i_in.ready = w_en;

    // input register
    logic                  r0_valid;
    logic [DIST_WIDTH-1:0] r0_qd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_valid <= 1'b0;
        end else if (w_en) begin
            r0_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r0_qd <= i_in.query_distance;
        end
    end

    // distance fraction: clamp, then d * 2^16 / L
    logic          w0_neg;
    logic          w0_full;
    logic [CW-1:0] w0_qd;

    assign w0_neg  = r0_qd[DIST_WIDTH-1];
    assign w0_qd   = CW'(r0_qd);
    assign w0_full = !w0_neg && (w0_qd >= CW'(r_len));

    logic             d1_val  [0:S1N];
    logic [LEN_W-1:0] d1_rem  [0:S1N];
    logic [S1N-1:0]   d1_xq   [0:S1N];
    logic [1:0]       d1_side [0:S1N];

    assign d1_val[0]  = r0_valid;
    assign d1_rem[0]  = (w0_neg || w0_full) ? '0 : w0_qd[LEN_W-1:0];
    assign d1_xq[0]   = '0;
    assign d1_side[0] = {w0_neg, w0_full};

    for (genvar g = 0; g < S1N; g++) begin : g_div1
        cadt_div_cell #(.DW(LEN_W), .LW(S1N), .SW(2)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (d1_val[g]),
            .i_div   (r_len),
            .i_rem   (d1_rem[g]),
            .i_xq    (d1_xq[g]),
            .i_side  (d1_side[g]),
            .o_valid (d1_val[g+1]),
            .o_rem   (d1_rem[g+1]),
            .o_xq    (d1_xq[g+1]),
            .o_side  (d1_side[g+1])
        );
    end

    logic [FRAC_W-1:0] w1_s;
    logic [FRAC_W-1:0] w1_ns;

    assign w1_s  = d1_side[S1N][1] ? '0 :
                   d1_side[S1N][0] ? ONE_Q16 : {1'b0, d1_xq[S1N]};
    assign w1_ns = ONE_Q16 - w1_s;

    // radicand partial products
    logic              rm1_valid;
    logic [FRAC_W-1:0] rm1_s;
    logic [PP_W-1:0]   rm1_p0h;
    logic [PP_W-1:0]   rm1_p0l;
    logic [PP_W-1:0]   rm1_p1h;
    logic [PP_W-1:0]   rm1_p1l;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rm1_valid <= 1'b0;
        end else if (w_en) begin
            rm1_valid <= d1_val[S1N];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            rm1_s   <= w1_s;
            rm1_p0h <= PP_W'(r_v0sq[SQ_W-1:SPD_W]) * PP_W'(w1_ns);
            rm1_p0l <= PP_W'(r_v0sq[SPD_W-1:0]) * PP_W'(w1_ns);
            rm1_p1h <= PP_W'(r_v1sq[SQ_W-1:SPD_W]) * PP_W'(w1_s);
            rm1_p1l <= PP_W'(r_v1sq[SPD_W-1:0]) * PP_W'(w1_s);
        end
    end

    // radicand sum
    logic [PP_W:0]          w2_hi;
    logic [PP_W:0]          w2_lo;
    logic [PP_W+SPD_W:0]    w2_q;
    logic                   rm2_valid;
    logic [FRAC_W-1:0]      rm2_s;
    logic [RAD_W-1:0]       rm2_q;

    assign w2_hi = (PP_W + 1)'(rm1_p0h) + (PP_W + 1)'(rm1_p1h);
    assign w2_lo = (PP_W + 1)'(rm1_p0l) + (PP_W + 1)'(rm1_p1l);
    assign w2_q  = {w2_hi, {SPD_W{1'b0}}} + (PP_W + SPD_W + 1)'(w2_lo);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rm2_valid <= 1'b0;
        end else if (w_en) begin
            rm2_valid <= rm1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            rm2_s <= rm1_s;
            rm2_q <= w2_q[RAD_W-1:0];
        end
    end

    // square root chain
    logic                sq_val  [0:ROOT_W];
    logic [ROOT_W+1:0]   sq_rem  [0:ROOT_W];
    logic [ROOT_W-1:0]   sq_root [0:ROOT_W];
    logic [RAD_W-1:0]    sq_qx   [0:ROOT_W];
    logic [FRAC_W-1:0]   sq_side [0:ROOT_W];

    assign sq_val[0]  = rm2_valid;
    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;
    assign sq_qx[0]   = rm2_q;
    assign sq_side[0] = rm2_s;

    for (genvar g = 0; g < ROOT_W; g++) begin : g_sqrt
        cadt_sqrt_cell #(.QW(RAD_W), .SW(FRAC_W)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (sq_val[g]),
            .i_rem   (sq_rem[g]),
            .i_root  (sq_root[g]),
            .i_qx    (sq_qx[g]),
            .i_side  (sq_side[g]),
            .o_valid (sq_val[g+1]),
            .o_rem   (sq_rem[g+1]),
            .o_root  (sq_root[g+1]),
            .o_qx    (sq_qx[g+1]),
            .o_side  (sq_side[g+1])
        );
    end

    // root minus scaled start speed, reversed when slowing down, floored at zero
    logic [ROOT_W-1:0] w3_v0s;
    logic [ROOT_W-1:0] w3_r;
    logic              rn_valid;
    logic [FRAC_W-1:0] rn_s;
    logic [ROOT_W-1:0] rn_num;

    assign w3_v0s = {r_v0, 8'h00};
    assign w3_r   = sq_root[ROOT_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rn_valid <= 1'b0;
        end else if (w_en) begin
            rn_valid <= sq_val[ROOT_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            rn_s <= sq_side[ROOT_W];
            if (r_inc) begin
                rn_num <= (w3_r > w3_v0s) ? (w3_r - w3_v0s) : '0;
            end else begin
                rn_num <= (w3_v0s > w3_r) ? (w3_v0s - w3_r) : '0;
            end
        end
    end

    // time fraction: num * 256 / |v1 - v0|, saturating past 17 bits
    logic [DEN_W-1:0]  w4_hi;
    logic              w4_sat;

    assign w4_hi  = DEN_W'(rn_num[ROOT_W-1:9]);
    assign w4_sat = (w4_hi >= r_den);

    logic              d2_val  [0:S2N];
    logic [DEN_W-1:0]  d2_rem  [0:S2N];
    logic [S2N-1:0]    d2_xq   [0:S2N];
    logic [FRAC_W:0]   d2_side [0:S2N];

    assign d2_val[0]  = rn_valid;
    assign d2_rem[0]  = w4_sat ? '0 : w4_hi;
    assign d2_xq[0]   = {rn_num[8:0], 8'h00};
    assign d2_side[0] = {w4_sat, rn_s};

    for (genvar g = 0; g < S2N; g++) begin : g_div2
        cadt_div_cell #(.DW(DEN_W), .LW(S2N), .SW(FRAC_W + 1)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (d2_val[g]),
            .i_div   (r_den),
            .i_rem   (d2_rem[g]),
            .i_xq    (d2_xq[g]),
            .i_side  (d2_side[g]),
            .o_valid (d2_val[g+1]),
            .o_rem   (d2_rem[g+1]),
            .o_xq    (d2_xq[g+1]),
            .o_side  (d2_side[g+1])
        );
    end

    // time fraction select and clamp
    logic [FRAC_W-1:0] w5_q;
    logic              rt_valid;
    logic [FRAC_W-1:0] rt_t;

    assign w5_q = d2_xq[S2N];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rt_valid <= 1'b0;
        end else if (w_en) begin
            rt_valid <= d2_val[S2N];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (r_len == '0) begin
                rt_t <= ONE_Q16;
            end else if (r_eq) begin
                rt_t <= d2_side[S2N][FRAC_W-1:0];
            end else if (d2_side[S2N][FRAC_W] || (w5_q > ONE_Q16)) begin
                rt_t <= ONE_Q16;
            end else begin
                rt_t <= w5_q;
            end
        end
    end

    // products for elapsed time and speed
    logic                    rp_valid;
    logic [FRAC_W-1:0]       rp_t;
    logic [LEN_W+FRAC_W-1:0] rp_prod;
    logic [PP_W-1:0]         rp_a;
    logic [PP_W-1:0]         rp_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rp_valid <= 1'b0;
        end else if (w_en) begin
            rp_valid <= rt_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            rp_t    <= rt_t;
            rp_prod <= (LEN_W + FRAC_W)'(r_len) * (LEN_W + FRAC_W)'(rt_t);
            rp_a    <= PP_W'(r_v0) * PP_W'(ONE_Q16 - rt_t);
            rp_b    <= PP_W'(r_v1) * PP_W'(rt_t);
        end
    end

    // elapsed time: L*T*2^(F+1) / (vs*256), saturating at 32 bits
    logic [NW-1:0]     w6_n;
    logic [VS_W-1:0]   w6_hi;
    logic              w6_sat;
    logic              w6_vz;
    logic [PP_W:0]     w6_sum;
    logic [SPD_W-1:0]  w6_spd;

    assign w6_n   = NW'(rp_prod) << (SPEED_FRAC_BITS + 1);
    assign w6_hi  = VS_W'(w6_n[NW-1:TIME_W]);
    assign w6_sat = (w6_hi >= r_vs8);
    assign w6_vz  = (r_vs8 == '0);
    assign w6_sum = (PP_W + 1)'(rp_a) + (PP_W + 1)'(rp_b);
    assign w6_spd = w6_sum[SPD_W+15:16];

    logic              d3_val  [0:S3N];
    logic [VS_W-1:0]   d3_rem  [0:S3N];
    logic [S3N-1:0]    d3_xq   [0:S3N];
    logic [SD3_W-1:0]  d3_side [0:S3N];

    assign d3_val[0]  = rp_valid;
    assign d3_rem[0]  = w6_sat ? '0 : w6_hi;
    assign d3_xq[0]   = w6_n[TIME_W-1:0];
    assign d3_side[0] = {w6_vz, w6_sat, rp_t, w6_spd};

    for (genvar g = 0; g < S3N; g++) begin : g_div3
        cadt_div_cell #(.DW(VS_W), .LW(S3N), .SW(SD3_W)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (d3_val[g]),
            .i_div   (r_vs8),
            .i_rem   (d3_rem[g]),
            .i_xq    (d3_xq[g]),
            .i_side  (d3_side[g]),
            .o_valid (d3_val[g+1]),
            .o_rem   (d3_rem[g+1]),
            .o_xq    (d3_xq[g+1]),
            .o_side  (d3_side[g+1])
        );
    end

    // output register
    logic [FRAC_W-1:0] r_out_t;
    logic [TIME_W-1:0] r_out_el;
    logic [SPD_W-1:0]  r_out_spd;
    logic              w7_vz;
    logic              w7_sat;

    assign w7_vz  = d3_side[S3N][SD3_W-1];
    assign w7_sat = d3_side[S3N][SD3_W-2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= d3_val[S3N];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_t   <= d3_side[S3N][SPD_W+FRAC_W-1:SPD_W];
            r_out_spd <= d3_side[S3N][SPD_W-1:0];
            if (w7_vz) begin
                r_out_el <= '0;
            end else if (w7_sat) begin
                r_out_el <= '1;
            end else begin
                r_out_el <= d3_xq[S3N];
            end
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.time_fraction  = r_out_t;
    assign o_out.elapsed_time   = r_out_el;
    assign o_out.speed_at_point = r_out_spd;

    // checks
    `CADT_ASSERT_NOW(a_frac_max, r_out_valid, (r_out_t <= ONE_Q16), "time fraction above one")
    `CADT_ASSERT_NOW(a_zero_time, (r_out_valid && (r_out_t == '0)), (r_out_el == '0), "time without progress")
    `CADT_ASSERT_NEXT(a_accept_enters, (i_in.valid && w_en), r0_valid, "accepted word lost at entry")

endmodule

`default_nettype wire
